/* src/head_pose_limiter_unit_defines.svh */
// Assertion macros shared by the head pose limiter RTL.
`ifndef HEAD_POSE_LIMITER_UNIT_DEFINES_SVH
`define HEAD_POSE_LIMITER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked at every edge outside reset.
`define HPL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define HPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPL_ASSERT(lbl, clk, rst, prop, msg)
`define HPL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* src/hpl_pkg.sv */
`timescale 1ns / 1ps
// Package: payload types, formats and CORDIC angle table of the head pose limiter.
package hpl_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TAB_LEN      = 24;

  localparam int POS_W       = 20;
  localparam int QUAT_W      = 16;
  localparam int PITCH_LIM_W = 13;
  localparam int YAW_LIM_W   = 14;
  localparam int POS_LIM_W   = 19;
  localparam int CFG_W       = 19;
  localparam int CFG_IDX_W   = 3;

  localparam int PROD_W = 32;   // product of two components
  localparam int SUM_W  = 35;   // sine / cosine terms, Q28
  localparam int ROOT_W = 29;   // floor sqrt of the pitch cosine term
  localparam int REM_W  = 2 * ROOT_W - 1;
  localparam int ANG_W  = 26;   // angle, 1/65536 degree
  localparam int VEC_W  = 37;   // vectoring CORDIC x / y
  localparam int ROT_W  = 33;   // rotation CORDIC x / y, Q30
  localparam int TRIG_W = 18;   // sine / cosine, Q16
  localparam int FULL_W = 56;   // triple products, Q48

  localparam int TRIG_SHIFT = 14;
  localparam int OUT_SHIFT  = 34;
  localparam int SPLIT_W    = 17;

  localparam logic signed [ANG_W-1:0] ANG_HALF    = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] ANG_FULL    = 26'sd23592960;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 26'sd5898240;
  localparam logic signed [SUM_W-1:0] ONE_Q28     = 35'sd268435456;
  localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [ROT_W-1:0] TRIG_RND    = 33'sd8192;
  localparam logic signed [FULL_W-1:0] OUT_RND    = 56'sd8589934592;
  localparam logic signed [FULL_W-1:0] Q14_ONE    = 56'sd16384;

  localparam logic [PITCH_LIM_W-1:0] PITCH_LIMIT_RST = 13'd5760;
  localparam logic [YAW_LIM_W-1:0]   YAW_LIMIT_RST   = 14'd11520;
  localparam logic [POS_LIM_W-1:0]   POS_LIMIT_RST   = 19'd524287;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LIMIT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LIMIT_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LIMIT_Z = 3'd4;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } pose_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  lim_pos_x;
    logic signed [POS_W-1:0]  lim_pos_y;
    logic signed [POS_W-1:0]  lim_pos_z;
    logic signed [QUAT_W-1:0] lim_quat_w;
    logic signed [QUAT_W-1:0] lim_quat_x;
    logic signed [QUAT_W-1:0] lim_quat_y;
    logic signed [QUAT_W-1:0] lim_quat_z;
  } lim_pose_t;

  // atan(2^-i) in 1/65536 degree, rounded
  function automatic logic signed [ANG_W-1:0] atan_ang(input int idx);
    case (idx)
      0:  return 26'sd2949120;
      1:  return 26'sd1740967;
      2:  return 26'sd919879;
      3:  return 26'sd466945;
      4:  return 26'sd234379;
      5:  return 26'sd117304;
      6:  return 26'sd58666;
      7:  return 26'sd29335;
      8:  return 26'sd14668;
      9:  return 26'sd7334;
      10: return 26'sd3667;
      11: return 26'sd1833;
      12: return 26'sd917;
      13: return 26'sd458;
      14: return 26'sd229;
      15: return 26'sd115;
      16: return 26'sd57;
      17: return 26'sd29;
      18: return 26'sd14;
      19: return 26'sd7;
      20: return 26'sd4;
      21: return 26'sd2;
      22: return 26'sd1;
      default: return 26'sd0;
    endcase
  endfunction

endpackage

/* src/hpl_delay.sv */
`timescale 1ns / 1ps
// Enabled shift line that carries side data alongside the pipeline.
module hpl_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

/* src/hpl_isqrt.sv */
`timescale 1ns / 1ps
// Pipelined floor square root, one root bit per stage.
module hpl_isqrt #(
  parameter int ROOT_W = hpl_pkg::ROOT_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-2:0]   rem,
  output logic [ROOT_W-1:0]     root
);

  localparam int RW = 2 * ROOT_W + 1;

  logic [RW-1:0]     r_st [ROOT_W];
  logic [ROOT_W-1:0] q_st [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
    localparam int K = ROOT_W - 1 - j;
    logic [RW-1:0]     r_in;
    logic [ROOT_W-1:0] q_in;
    logic [RW-1:0]     d;

    if (j == 0) begin : g_first
      assign r_in = RW'(rem);
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_st[j-1];
      assign q_in = q_st[j-1];
    end

    // (q + 2^k)^2 - q^2
    assign d = (RW'(q_in) << (K + 1)) + (RW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (en) begin
        if (r_in >= d) begin
          r_st[j] <= r_in - d;
          q_st[j] <= q_in | (ROOT_W'(1) << K);
        end else begin
          r_st[j] <= r_in;
          q_st[j] <= q_in;
        end
      end
    end
  end

  assign root = q_st[ROOT_W-1];

endmodule

/* src/hpl_vec_cordic.sv */
`timescale 1ns / 1ps
// Vectoring CORDIC: atan2(y, x) in 1/65536 degree, one stage per register.
module hpl_vec_cordic #(
  parameter int STAGES = hpl_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [hpl_pkg::VEC_W-1:0]  y_in,
  input  logic signed [hpl_pkg::VEC_W-1:0]  x_in,
  output logic signed [hpl_pkg::ANG_W-1:0]  ang
);
  import hpl_pkg::*;

  logic signed [VEC_W-1:0] xs [STAGES+1];
  logic signed [VEC_W-1:0] ys [STAGES+1];
  logic signed [ANG_W-1:0] zs [STAGES+1];
  logic                    zf [STAGES+1];
  logic signed [ANG_W-1:0] zl;

  // left half plane is folded over first
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[VEC_W-1]) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= y_in[VEC_W-1] ? -ANG_HALF : ANG_HALF;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATAN = atan_ang(i);
    logic signed [VEC_W-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!ys[i][VEC_W-1]) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + ATAN;
        end else begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - ATAN;
        end
      end
    end
  end

  assign zl = zs[STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zf[STAGES]) begin
        ang <= '0;
      end else if (zl > ANG_HALF) begin
        ang <= zl - ANG_FULL;
      end else if (zl < -ANG_HALF) begin
        ang <= zl + ANG_FULL;
      end else begin
        ang <= zl;
      end
    end
  end

endmodule

/* src/hpl_rot_cordic.sv */
`timescale 1ns / 1ps
// Rotation CORDIC: cosine and sine of an angle, rounded to Q16.
module hpl_rot_cordic #(
  parameter int STAGES = hpl_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [hpl_pkg::ANG_W-1:0]   z_in,
  output logic signed [hpl_pkg::TRIG_W-1:0]  cos_o,
  output logic signed [hpl_pkg::TRIG_W-1:0]  sin_o
);
  import hpl_pkg::*;

  logic signed [ROT_W-1:0] xs [STAGES];
  logic signed [ROT_W-1:0] ys [STAGES];
  logic signed [ANG_W-1:0] zs [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATAN = atan_ang(i);
    logic signed [ROT_W-1:0] x_i, y_i, dx, dy;
    logic signed [ANG_W-1:0] z_i;

    if (i == 0) begin : g_first
      assign x_i = INV_GAIN_Q30;
      assign y_i = '0;
      assign z_i = z_in;
    end else begin : g_next
      assign x_i = xs[i-1];
      assign y_i = ys[i-1];
      assign z_i = zs[i-1];
    end

    assign dx = y_i >>> i;
    assign dy = x_i >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_i[ANG_W-1]) begin
          xs[i] <= x_i - dx;
          ys[i] <= y_i + dy;
          zs[i] <= z_i - ATAN;
        end else begin
          xs[i] <= x_i + dx;
          ys[i] <= y_i - dy;
          zs[i] <= z_i + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= TRIG_W'((xs[STAGES-1] + TRIG_RND) >>> TRIG_SHIFT);
      sin_o <= TRIG_W'((ys[STAGES-1] + TRIG_RND) >>> TRIG_SHIFT);
    end
  end

endmodule

/* src/head_pose_limiter_unit.sv */
`timescale 1ns / 1ps
// Top level of the head pose limiter: pipeline control, front and back end.
//
// Use: one pose item per cycle on the pose channel (pose_valid / pose_stall,
// payload pose). Each axis of the position is clamped to +/- its limit; the
// quaternion is split into pitch, yaw and roll (Z-Y-X), pitch and yaw are
// clamped to their limits, and the angles are rebuilt into a quaternion.
// One result item leaves per pose on the lim channel (lim_valid / lim_stall).
// Latency is set by the 29 stage square root, the vectoring and rotation
// CORDIC chains and the multiply / round tail. Throughput: one item per
// cycle while the pipeline advances. The whole pipeline moves on a common
// advance: it holds only while the output register is full and the
// receiver stalls; bubbles travel as cleared valid bits. Limits are written
// over the cfg port (cfg_we, cfg_index, cfg_data); the user must write them
// only while the pipeline is empty; the block does not enforce it. Unknown
// indexes are ignored. Synchronous reset empties the pipeline and loads the
// default limits (90 deg pitch, 180 deg yaw, full position range).
`include "head_pose_limiter_unit_defines.svh"
module head_pose_limiter_unit #(
  parameter int CORDIC_STAGES = hpl_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pose_valid,
  output logic                            pose_stall,
  input  hpl_pkg::pose_t                  pose,
  output logic                            lim_valid,
  input  logic                            lim_stall,
  output hpl_pkg::lim_pose_t              lim,
  input  logic                            cfg_we,
  input  logic [hpl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpl_pkg::CFG_W-1:0]       cfg_data
);
  import hpl_pkg::*;

  // stage numbering: 1 front products ... LAT output register
  localparam int LAT       = 2 * CORDIC_STAGES + 41;
  localparam int SIDE_DLY  = ROOT_W + 2;          // sums -> square root out
  localparam int VEC_DLY   = CORDIC_STAGES + 2;   // vectoring latency
  localparam int CLAMP_IDX = CORDIC_STAGES + 35;  // valid bit of clamp stage
  localparam int POS_DLY   = LAT - 1;

  typedef struct packed {
    logic signed [SUM_W-1:0]  siny;
    logic signed [SUM_W-1:0]  cosy;
    logic signed [SUM_W-1:0]  sinr;
    logic signed [SUM_W-1:0]  cosr;
    logic signed [ROOT_W-1:0] sinp;
    logic                     satp;
    logic                     satn;
  } side_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  // ---------------- configuration ----------------
  logic [PITCH_LIM_W-1:0] pitch_limit;
  logic [YAW_LIM_W-1:0]   yaw_limit;
  logic [POS_LIM_W-1:0]   pos_limit_x, pos_limit_y, pos_limit_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_limit <= PITCH_LIMIT_RST;
      yaw_limit   <= YAW_LIMIT_RST;
      pos_limit_x <= POS_LIMIT_RST;
      pos_limit_y <= POS_LIMIT_RST;
      pos_limit_z <= POS_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PITCH_LIMIT: pitch_limit <= cfg_data[PITCH_LIM_W-1:0];
        REG_YAW_LIMIT:   yaw_limit   <= cfg_data[YAW_LIM_W-1:0];
        REG_POS_LIMIT_X: pos_limit_x <= cfg_data[POS_LIM_W-1:0];
        REG_POS_LIMIT_Y: pos_limit_y <= cfg_data[POS_LIM_W-1:0];
        REG_POS_LIMIT_Z: pos_limit_z <= cfg_data[POS_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  // Everything advances together unless the output item is held.
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv        = !vld[LAT-1] || !lim_stall;
  assign pose_stall = !adv;
  assign lim_valid  = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], pose_valid};
    end
  end

  function automatic logic signed [POS_W-1:0] clamp_pos(
    input logic signed [POS_W-1:0] v,
    input logic [POS_LIM_W-1:0]    l
  );
    logic signed [POS_W:0] ls;
    ls = $signed({2'b00, l});
    if (v > ls) return ls[POS_W-1:0];
    if (v < -ls) return POS_W'(-ls);
    return v;
  endfunction

  // ---------------- stage 1: products, position clamp ----------------
  logic signed [PROD_W-1:0] s1_wy, s1_zx, s1_wz, s1_xy, s1_wx, s1_yz;
  logic signed [PROD_W-1:0] s1_xx, s1_yy, s1_zz;
  pos_t                     s1_pos;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_wy <= pose.quat_w * pose.quat_y;
      s1_zx <= pose.quat_z * pose.quat_x;
      s1_wz <= pose.quat_w * pose.quat_z;
      s1_xy <= pose.quat_x * pose.quat_y;
      s1_wx <= pose.quat_w * pose.quat_x;
      s1_yz <= pose.quat_y * pose.quat_z;
      s1_xx <= pose.quat_x * pose.quat_x;
      s1_yy <= pose.quat_y * pose.quat_y;
      s1_zz <= pose.quat_z * pose.quat_z;
      s1_pos.x <= clamp_pos(pose.pos_x, pos_limit_x);
      s1_pos.y <= clamp_pos(pose.pos_y, pos_limit_y);
      s1_pos.z <= clamp_pos(pose.pos_z, pos_limit_z);
    end
  end

  // ---------------- stage 2: sine / cosine terms in Q28 ----------------
  logic signed [SUM_W-1:0] s2_sinp, s2_siny, s2_cosy, s2_sinr, s2_cosr;
  side_t                   s2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sinp <= (SUM_W'(s1_wy) - SUM_W'(s1_zx)) <<< 1;
      s2_siny <= (SUM_W'(s1_wz) + SUM_W'(s1_xy)) <<< 1;
      s2_cosy <= ONE_Q28 - ((SUM_W'(s1_yy) + SUM_W'(s1_zz)) <<< 1);
      s2_sinr <= (SUM_W'(s1_wx) + SUM_W'(s1_yz)) <<< 1;
      s2_cosr <= ONE_Q28 - ((SUM_W'(s1_xx) + SUM_W'(s1_yy)) <<< 1);
    end
  end

  // pitch term at or beyond one saturates; otherwise it fits ROOT_W signed bits
  always_comb begin
    s2_side.siny = s2_siny;
    s2_side.cosy = s2_cosy;
    s2_side.sinr = s2_sinr;
    s2_side.cosr = s2_cosr;
    s2_side.sinp = s2_sinp[ROOT_W-1:0];
    s2_side.satp = (s2_sinp >= ONE_Q28);
    s2_side.satn = (s2_sinp <= -ONE_Q28);
  end

  // ---------------- stages 3-4: 1 - s^2 for the asin ----------------
  logic signed [2*ROOT_W-1:0] sq_full;
  logic [REM_W-1:0]           s3_sq, s4_rem;

  assign sq_full = s2_side.sinp * s2_side.sinp;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sq  <= sq_full[REM_W-1:0];
      s4_rem <= (REM_W'(1) << (REM_W - 1)) - s3_sq;
    end
  end

  logic [ROOT_W-1:0] root;
  side_t             side_d;
  logic [1:0]        sat_d;

  hpl_isqrt #(.ROOT_W(ROOT_W)) u_isqrt (
    .clk  (clk),
    .en   (adv),
    .rem  (s4_rem),
    .root (root)
  );

  hpl_delay #(.WIDTH($bits(side_t)), .DEPTH(SIDE_DLY)) u_side_dly (
    .clk  (clk),
    .en   (adv),
    .din  (s2_side),
    .dout (side_d)
  );

  // ---------------- angle extraction ----------------
  logic signed [ANG_W-1:0] v_pitch, v_yaw, v_roll;

  hpl_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec_pitch (
    .clk  (clk),
    .en   (adv),
    .y_in (VEC_W'(side_d.sinp)),
    .x_in ($signed(VEC_W'(root))),
    .ang  (v_pitch)
  );

  hpl_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec_yaw (
    .clk  (clk),
    .en   (adv),
    .y_in (VEC_W'(side_d.siny)),
    .x_in (VEC_W'(side_d.cosy)),
    .ang  (v_yaw)
  );

  hpl_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec_roll (
    .clk  (clk),
    .en   (adv),
    .y_in (VEC_W'(side_d.sinr)),
    .x_in (VEC_W'(side_d.cosr)),
    .ang  (v_roll)
  );

  hpl_delay #(.WIDTH(2), .DEPTH(VEC_DLY)) u_sat_dly (
    .clk  (clk),
    .en   (adv),
    .din  ({side_d.satp, side_d.satn}),
    .dout (sat_d)
  );

  // ---------------- angle clamp ----------------
  // Limits in 1/64 degree become angle units by a 10 bit shift.
  logic signed [ANG_W-1:0] pitch_lim, yaw_lim, pitch_sel;
  logic signed [ANG_W-1:0] cl_pitch, cl_yaw, cl_roll;

  assign pitch_lim = $signed(ANG_W'({pitch_limit, 10'b0}));
  assign yaw_lim   = $signed(ANG_W'({yaw_limit, 10'b0}));

  always_comb begin
    if (sat_d[1]) begin
      pitch_sel = ANG_QUARTER;
    end else if (sat_d[0]) begin
      pitch_sel = -ANG_QUARTER;
    end else begin
      pitch_sel = v_pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pitch_sel > pitch_lim) begin
        cl_pitch <= pitch_lim;
      end else if (pitch_sel < -pitch_lim) begin
        cl_pitch <= -pitch_lim;
      end else begin
        cl_pitch <= pitch_sel;
      end
      if (v_yaw > yaw_lim) begin
        cl_yaw <= yaw_lim;
      end else if (v_yaw < -yaw_lim) begin
        cl_yaw <= -yaw_lim;
      end else begin
        cl_yaw <= v_yaw;
      end
      cl_roll <= v_roll;
    end
  end

  // ---------------- half-angle sine / cosine ----------------
  logic signed [TRIG_W-1:0] cp, sp, cy, sy, cr, sr;

  hpl_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_pitch (
    .clk   (clk),
    .en    (adv),
    .z_in  (cl_pitch >>> 1),
    .cos_o (cp),
    .sin_o (sp)
  );

  hpl_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_yaw (
    .clk   (clk),
    .en    (adv),
    .z_in  (cl_yaw >>> 1),
    .cos_o (cy),
    .sin_o (sy)
  );

  hpl_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_roll (
    .clk   (clk),
    .en    (adv),
    .z_in  (cl_roll >>> 1),
    .cos_o (cr),
    .sin_o (sr)
  );

  // ---------------- quaternion rebuild ----------------
  localparam int PAIR_W = 2 * TRIG_W;
  localparam int HI_W   = PAIR_W - SPLIT_W;

  // pair index: 0 cp*cy, 1 sp*sy, 2 sp*cy, 3 cp*sy; roll index: 0 cr, 1 sr
  logic signed [PAIR_W-1:0]      m1_pair [4];
  logic signed [TRIG_W-1:0]      m1_cr, m1_sr;
  logic signed [HI_W+TRIG_W-1:0] m2_hi [2][4];
  logic signed [PAIR_W-1:0]      m2_lo [2][4];
  logic signed [FULL_W-1:0]      rs_w, rs_x, rs_y, rs_z;
  logic signed [QUAT_W-1:0]      ro_w, ro_x, ro_y, ro_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_pair[0] <= cp * cy;
      m1_pair[1] <= sp * sy;
      m1_pair[2] <= sp * cy;
      m1_pair[3] <= cp * sy;
      m1_cr      <= cr;
      m1_sr      <= sr;
    end
  end

  // pair split in high and low halves keeps each multiply near 18x19
  for (genvar p = 0; p < 4; p++) begin : g_split
    logic signed [HI_W-1:0]   hi;
    logic signed [TRIG_W-1:0] lo;
    assign hi = m1_pair[p][PAIR_W-1:SPLIT_W];
    assign lo = $signed({1'b0, m1_pair[p][SPLIT_W-1:0]});

    always_ff @(posedge clk) begin
      if (adv) begin
        m2_hi[0][p] <= m1_cr * hi;
        m2_hi[1][p] <= m1_sr * hi;
        m2_lo[0][p] <= m1_cr * lo;
        m2_lo[1][p] <= m1_sr * lo;
      end
    end
  end

  function automatic logic signed [FULL_W-1:0] joint(
    input logic signed [HI_W+TRIG_W-1:0] hi,
    input logic signed [PAIR_W-1:0]      lo
  );
    return (FULL_W'(hi) <<< SPLIT_W) + FULL_W'(lo);
  endfunction

  function automatic logic signed [QUAT_W-1:0] to_q14(input logic signed [FULL_W-1:0] v);
    logic signed [FULL_W-1:0] q;
    q = (v + OUT_RND) >>> OUT_SHIFT;
    if (q > Q14_ONE) return QUAT_W'(Q14_ONE);
    if (q < -Q14_ONE) return QUAT_W'(-Q14_ONE);
    return q[QUAT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_w <= joint(m2_hi[0][0], m2_lo[0][0]) + joint(m2_hi[1][1], m2_lo[1][1]);
      rs_x <= joint(m2_hi[1][0], m2_lo[1][0]) - joint(m2_hi[0][1], m2_lo[0][1]);
      rs_y <= joint(m2_hi[0][2], m2_lo[0][2]) + joint(m2_hi[1][3], m2_lo[1][3]);
      rs_z <= joint(m2_hi[0][3], m2_lo[0][3]) - joint(m2_hi[1][2], m2_lo[1][2]);
      ro_w <= to_q14(rs_w);
      ro_x <= to_q14(rs_x);
      ro_y <= to_q14(rs_y);
      ro_z <= to_q14(rs_z);
    end
  end

  // ---------------- output ----------------
  pos_t pos_d;

  hpl_delay #(.WIDTH($bits(pos_t)), .DEPTH(POS_DLY)) u_pos_dly (
    .clk  (clk),
    .en   (adv),
    .din  (s1_pos),
    .dout (pos_d)
  );

  always_comb begin
    lim.lim_pos_x  = pos_d.x;
    lim.lim_pos_y  = pos_d.y;
    lim.lim_pos_z  = pos_d.z;
    lim.lim_quat_w = ro_w;
    lim.lim_quat_x = ro_x;
    lim.lim_quat_y = ro_y;
    lim.lim_quat_z = ro_z;
  end

  // ---------------- checks ----------------
  logic pos_ok, quat_ok, pitch_ok;

  assign pos_ok =
    (lim.lim_pos_x <= $signed({1'b0, pos_limit_x})) &&
    (lim.lim_pos_x >= -$signed({1'b0, pos_limit_x})) &&
    (lim.lim_pos_y <= $signed({1'b0, pos_limit_y})) &&
    (lim.lim_pos_y >= -$signed({1'b0, pos_limit_y})) &&
    (lim.lim_pos_z <= $signed({1'b0, pos_limit_z})) &&
    (lim.lim_pos_z >= -$signed({1'b0, pos_limit_z}));

  assign quat_ok =
    (ro_w <= 16'sd16384) && (ro_w >= -16'sd16384) &&
    (ro_x <= 16'sd16384) && (ro_x >= -16'sd16384) &&
    (ro_y <= 16'sd16384) && (ro_y >= -16'sd16384) &&
    (ro_z <= 16'sd16384) && (ro_z >= -16'sd16384);

  assign pitch_ok = (cl_pitch <= pitch_lim) && (cl_pitch >= -pitch_lim);

  `HPL_ASSERT(a_accept_enters, clk, rst, ((pose_valid && !pose_stall) |=> vld[0]), "item lost")
  `HPL_ASSERT(a_pitch_clamped, clk, rst, (vld[CLAMP_IDX] |-> pitch_ok), "pitch beyond limit")
  `HPL_ASSERT(a_pos_limited, clk, rst, (lim_valid |-> pos_ok), "position beyond limit")
  `HPL_ASSERT(a_quat_range, clk, rst, (lim_valid |-> quat_ok), "quaternion out of range")
  `HPL_ASSERT_ALWAYS(a_reset_empty, clk, ($past(rst) |-> !lim_valid), "output valid after reset")

endmodule

/* tb/head_pose_limiter_unit_checker.sv */
`timescale 1ns / 1ps
// Checker: watches the pose and limit channels, predicts limited poses, compares.
module head_pose_limiter_unit_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pose_valid,
  input  logic                          pose_stall,
  input  hpl_pkg::pose_t                pose,
  input  logic                          lim_valid,
  input  logic                          lim_stall,
  input  hpl_pkg::lim_pose_t            lim,
  input  logic                          cfg_we,
  input  logic [hpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpl_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import hpl_pkg::*;

  localparam int NSTAGE = (CORDIC_STAGES_DEF > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STAGES_DEF;

  longint unsigned pitch_lim, yaw_lim, plim_x, plim_y, plim_z;
  lim_pose_t       limited_poses[$];

  function automatic longint atan_step(int i);
    case (i)
      0: return 2949120;  1: return 1740967; 2: return 919879; 3: return 466945;
      4: return 234379;   5: return 117304;  6: return 58666;  7: return 29335;
      8: return 14668;    9: return 7334;    10: return 3667;  11: return 1833;
      12: return 917;     13: return 458;    14: return 229;   15: return 115;
      16: return 57;      17: return 29;     18: return 14;    19: return 7;
      20: return 4;       21: return 2;      22: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint clamp_mag(longint v, longint m);
    if (v > m) return m;
    if (v < -m) return -m;
    return v;
  endfunction

  // floor sqrt by bit pairs
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 11796480 : -11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTAGE; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    if (z > 11796480) z -= 23592960;
    if (z < -11796480) z += 23592960;
    return z;
  endfunction

  task automatic half_sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, dx, dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < NSTAGE; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x -= dx; y += dy; ang -= atan_step(i);
      end else begin
        x += dx; y -= dy; ang += atan_step(i);
      end
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
  endtask

  function automatic logic signed [QUAT_W-1:0] round_q14(longint v);
    return QUAT_W'(clamp_mag((v + (64'sd1 <<< 33)) >>> 34, 16384));
  endfunction

  task automatic predict_limited(input pose_t p, output lim_pose_t r);
    longint w, x, y, z, sp_term, pitch, yaw, roll;
    longint cp, sp, cy, sy, cr, sr, cpcy, spsy, spcy, cpsy;
    longint unsigned rem;
    w = p.quat_w; x = p.quat_x; y = p.quat_y; z = p.quat_z;
    r.lim_pos_x = POS_W'(clamp_mag(longint'(p.pos_x), longint'(plim_x)));
    r.lim_pos_y = POS_W'(clamp_mag(longint'(p.pos_y), longint'(plim_y)));
    r.lim_pos_z = POS_W'(clamp_mag(longint'(p.pos_z), longint'(plim_z)));
    sp_term = 2 * (w * y - z * x);
    if (sp_term >= 268435456) pitch = 5898240;
    else if (sp_term <= -268435456) pitch = -5898240;
    else begin
      rem = (64'd1 << 56) - longint'(sp_term * sp_term);
      pitch = vector_angle(sp_term, longint'(root_floor(rem)));
    end
    yaw  = vector_angle(2 * (w * z + x * y), 268435456 - 2 * (y * y + z * z));
    roll = vector_angle(2 * (w * x + y * z), 268435456 - 2 * (x * x + y * y));
    pitch = clamp_mag(pitch, longint'(pitch_lim) * 1024);
    yaw   = clamp_mag(yaw, longint'(yaw_lim) * 1024);
    half_sin_cos(pitch >>> 1, cp, sp);
    half_sin_cos(yaw >>> 1, cy, sy);
    half_sin_cos(roll >>> 1, cr, sr);
    cpcy = cp * cy; spsy = sp * sy; spcy = sp * cy; cpsy = cp * sy;
    r.lim_quat_w = round_q14(cr * cpcy + sr * spsy);
    r.lim_quat_x = round_q14(sr * cpcy - cr * spsy);
    r.lim_quat_y = round_q14(cr * spcy + sr * cpsy);
    r.lim_quat_z = round_q14(cr * cpsy - sr * spcy);
  endtask

  assign pending = limited_poses.size();

  always @(posedge clk) begin
    lim_pose_t exp_lim;
    if (rst) begin
      pitch_lim = PITCH_LIMIT_RST;
      yaw_lim   = YAW_LIMIT_RST;
      plim_x    = POS_LIMIT_RST;
      plim_y    = POS_LIMIT_RST;
      plim_z    = POS_LIMIT_RST;
      limited_poses.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PITCH_LIMIT: pitch_lim = cfg_data[PITCH_LIM_W-1:0];
          REG_YAW_LIMIT:   yaw_lim   = cfg_data[YAW_LIM_W-1:0];
          REG_POS_LIMIT_X: plim_x    = cfg_data[POS_LIM_W-1:0];
          REG_POS_LIMIT_Y: plim_y    = cfg_data[POS_LIM_W-1:0];
          REG_POS_LIMIT_Z: plim_z    = cfg_data[POS_LIM_W-1:0];
          default: ;
        endcase
      end
      if (lim_valid && !lim_stall) begin
        if (limited_poses.size() == 0) begin
          if (fail_count < 10) $display("unexpected limited pose %h", lim);
          fail_count <= fail_count + 1;
        end else begin
          exp_lim = limited_poses.pop_front();
          if (lim !== exp_lim) begin
            if (fail_count < 10)
              $display({"mismatch: pos %0d %0d %0d quat %0d %0d %0d %0d,",
                        " got %0d %0d %0d / %0d %0d %0d %0d"},
                       exp_lim.lim_pos_x, exp_lim.lim_pos_y, exp_lim.lim_pos_z,
                       exp_lim.lim_quat_w, exp_lim.lim_quat_x, exp_lim.lim_quat_y,
                       exp_lim.lim_quat_z, lim.lim_pos_x, lim.lim_pos_y, lim.lim_pos_z,
                       lim.lim_quat_w, lim.lim_quat_x, lim.lim_quat_y, lim.lim_quat_z);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (pose_valid && !pose_stall) begin
        predict_limited(pose, exp_lim);
        limited_poses.insert(limited_poses.size(), exp_lim);
      end
    end
  end

endmodule

/* tb/head_pose_limiter_unit_test.sv */
`timescale 1ns / 1ps
// Testbench top: drives poses and limit writes, gives the verdict.
module head_pose_limiter_unit_test;
  import hpl_pkg::*;

  // index outside the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 pose_valid;
  logic                 pose_stall;
  pose_t                pose;
  logic                 lim_valid;
  logic                 lim_stall;
  lim_pose_t            lim;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  bit                   calm;       // no idling near the end of the run

  head_pose_limiter_unit DUT (.*);
  head_pose_limiter_unit_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall bursts, none once calm
  initial begin
    int n;
    lim_stall = 1'b0;
    forever begin
      n = $urandom_range(1, 17);
      repeat (n) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        lim_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        lim_stall <= 1'b0;
      end
    end
  end

  // one write, then cfg_we low before the next, so back to back writes never collide
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // waits for the pipeline to drain before limits change
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // one pose; occasionally an idle burst before it
  task automatic send_pose(input pose_t p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pose_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    pose_valid <= 1'b1;
    pose       <= p;
    @(posedge clk);
    while (pose_stall) @(posedge clk);
  endtask

  task automatic idle_pose();
    pose_valid <= 1'b0;
  endtask

  function automatic logic signed [QUAT_W-1:0] rand_comp();
    return QUAT_W'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // a random pose; with unit_q set, the quaternion is scaled to near unit length by real math
  function automatic pose_t rand_pose(bit unit_q);
    pose_t p;
    real a, b, c, d, n;
    p.pos_x = POS_W'($urandom);
    p.pos_y = POS_W'($urandom);
    p.pos_z = POS_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      p.pos_x = $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
      p.pos_z = -p.pos_y;
    end
    p.quat_w = rand_comp();
    p.quat_x = rand_comp();
    p.quat_y = rand_comp();
    p.quat_z = rand_comp();
    if (unit_q) begin
      a = p.quat_w; b = p.quat_x; c = p.quat_y; d = p.quat_z;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n > 0.0) begin
        p.quat_w = QUAT_W'($rtoi(a * 16384.0 / n));
        p.quat_x = QUAT_W'($rtoi(b * 16384.0 / n));
        p.quat_y = QUAT_W'($rtoi(c * 16384.0 / n));
        p.quat_z = QUAT_W'($rtoi(d * 16384.0 / n));
      end
    end
    return p;
  endfunction

  function automatic pose_t make_pose(int px, int py, int pz, int w, int x, int y, int z);
    pose_t p;
    p.pos_x = POS_W'(px); p.pos_y = POS_W'(py); p.pos_z = POS_W'(pz);
    p.quat_w = QUAT_W'(w); p.quat_x = QUAT_W'(x);
    p.quat_y = QUAT_W'(y); p.quat_z = QUAT_W'(z);
    return p;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_pose(rand_pose($urandom_range(0, 9) != 0));
    idle_pose();
  endtask

  initial begin
    rst        = 1'b1;
    calm       = 1'b0;
    pose_valid = 1'b0;
    pose       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default limits, field extremes, zero vectors, pitch saturation
    send_pose(make_pose(0, 0, 0, 16384, 0, 0, 0));
    send_pose(make_pose(524287, -524288, -1, 0, 0, 0, 0));        // all-zero quaternion
    send_pose(make_pose(-524288, 524287, 1, 11585, 0, 11585, 0)); // pitch +90
    send_pose(make_pose(1, 2, 3, 11585, 0, -11585, 0));           // pitch -90
    send_pose(make_pose(0, 0, 0, 16384, 0, 16384, 0));            // pitch term beyond one
    send_pose(make_pose(0, 0, 0, 0, 0, 0, 16384));                // yaw 180
    send_pose(make_pose(0, 0, 0, 0, 16384, 0, 0));                // roll 180
    send_pose(make_pose(0, 0, 0, -16384, -16384, -16384, -16384));
    send_pose(make_pose(0, 0, 0, 16384, 16384, 16384, 16384));    // saturating outputs
    send_pose(make_pose(0, 0, 0, -1, 0, 0, 0));
    send_pose(make_pose(0, 0, 0, 0, 0, 0, -16384));
    send_pose(make_pose(0, 0, 0, 15137, 0, 0, 6270));             // yaw 45
    idle_pose();
    drain();

    // tight limits: position, pitch and yaw clamp to zero
    write_limit(REG_PITCH_LIMIT, 0);
    write_limit(REG_YAW_LIMIT, 0);
    write_limit(REG_POS_LIMIT_X, 0);
    write_limit(REG_POS_LIMIT_Y, 0);
    write_limit(REG_POS_LIMIT_Z, 0);
    write_limit(REG_UNKNOWN, 5);                                  // ignored
    send_pose(make_pose(524287, -524288, 7, 15137, 3000, 5000, 6270));
    send_pose(make_pose(0, 0, 0, 11585, 0, 11585, 0));
    random_phase(150);
    drain();

    // limits above range: pitch and yaw clamp nothing
    write_limit(REG_PITCH_LIMIT, 8191);
    write_limit(REG_YAW_LIMIT, 16383);
    write_limit(REG_POS_LIMIT_X, 524287);
    write_limit(REG_POS_LIMIT_Y, 1);
    write_limit(REG_POS_LIMIT_Z, 262144);
    random_phase(250);
    drain();

    // mid-range random limits
    for (int k = 0; k < 3; k++) begin
      write_limit(REG_PITCH_LIMIT, $urandom_range(0, 5760));
      write_limit(REG_YAW_LIMIT, $urandom_range(0, 11520));
      write_limit(REG_POS_LIMIT_X, $urandom_range(0, 524287));
      write_limit(REG_POS_LIMIT_Y, $urandom_range(0, 524287));
      write_limit(REG_POS_LIMIT_Z, $urandom_range(0, 524287));
      random_phase(200);
      drain();
    end

    // back to full range; last stretch with no idling
    write_limit(REG_PITCH_LIMIT, 5760);
    write_limit(REG_YAW_LIMIT, 11520);
    write_limit(REG_POS_LIMIT_X, 524287);
    write_limit(REG_POS_LIMIT_Y, 524287);
    write_limit(REG_POS_LIMIT_Z, 524287);
    random_phase(100);
    calm = 1'b1;
    random_phase(120);

    drain();
    if (fail_count == 0) begin
      $display("** head_pose_limiter_unit: PASSED **");
    end else begin
      $display("** head_pose_limiter_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** head_pose_limiter_unit: FAILED **");
    $finish;
  end

endmodule
